[hw/rtl/mjs_pkg.sv]
// Shared types, constants and ordering functions of the multi-core job scheduler.
// Used by mjs_cfg and multicore_job_scheduler_top; depends on nothing else.
package mjs_pkg;

   localparam int MAX_CORES   = 8;
   localparam int CORE_W      = $clog2(MAX_CORES);
   localparam int CORE_CNT_W  = $clog2(MAX_CORES + 1);
   localparam int QUEUE_DEPTH = 64;
   localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int OP_W       = 2;
   localparam int JOB_W      = 16;
   localparam int TIME_W     = 32;
   localparam int PRIO_W     = 8;
   localparam int CIDX_W     = 3;
   localparam int SCHEME_W   = 3;
   localparam int ACT_W      = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_NEW    = 2'd0;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
   localparam logic [OP_W-1:0] OP_EXPIRE = 2'd2;

   localparam logic [SCHEME_W-1:0] SCH_FCFS = 3'd0;
   localparam logic [SCHEME_W-1:0] SCH_SJF  = 3'd1;
   localparam logic [SCHEME_W-1:0] SCH_PSJF = 3'd2;
   localparam logic [SCHEME_W-1:0] SCH_PRI  = 3'd3;
   localparam logic [SCHEME_W-1:0] SCH_PPRI = 3'd4;
   localparam logic [SCHEME_W-1:0] SCH_RR   = 3'd5;

   localparam logic REG_SCHEME = 1'b0;
   localparam logic REG_ACTIVE = 1'b1;

   typedef struct packed {
      logic [JOB_W-1:0]  job;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] total;
      logic [TIME_W-1:0] left;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      entry_type         ent;
      logic [TIME_W-1:0] seg;
   } core_rec_type;

   typedef struct packed {
      logic [SCHEME_W-1:0]   scheme;
      logic [CORE_CNT_W-1:0] n_cores;
   } cfg_type;

   function automatic logic [TIME_W-1:0] key_of(input logic [SCHEME_W-1:0] scheme,
                                                input entry_type e);
      logic [TIME_W-1:0] k;
      case (scheme)
         SCH_FCFS: k = e.arrival;
         SCH_SJF:  k = e.total;
         SCH_PSJF: k = e.left;
         SCH_PRI, SCH_PPRI: k = TIME_W'(e.prio);
         default:  k = '0;
      endcase
      return k;
   endfunction

   function automatic logic sorts_before(input logic [SCHEME_W-1:0] scheme,
                                         input entry_type a, input entry_type b);
      logic [TIME_W-1:0] ka;
      logic [TIME_W-1:0] kb;
      logic              r;
      ka = key_of(scheme, a);
      kb = key_of(scheme, b);
      if (ka != kb) begin
         r = ka < kb;
      end else if (scheme inside {SCH_SJF, SCH_PSJF, SCH_PRI, SCH_PPRI}) begin
         r = a.arrival < b.arrival;
      end else begin
         r = 1'b0;
      end
      return r;
   endfunction

endpackage

[hw/rtl/multicore_job_scheduler_top.sv]
// Multi-core job scheduler: an item is accepted only while no other is being worked on.
// A new job that finds an idle core, or a finish with an empty queue, goes from decode
// straight to the output state. A preemption check walks the active cores one at a time
// through the core state memory. A sorted insertion into the wait queue memory examines
// queued entries and moves entries up one place at a time; the entries examined and the
// entries moved never exceed the queue length plus one in total. The result waits in an
// output register, so the next item may be accepted before it is taken.
// Depends on mjs_pkg and mjs_cfg.
module multicore_job_scheduler_top import mjs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // job_id[15:0], now[47:16], run_time[79:48], prio[87:80], core_index[90:88], zero fill
   input  logic [95:0]           req_tdata,
   // operation[1:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // core_out[2:0], job_out[18:3], overflow[19], zero fill
   output logic [23:0]           rsp_tdata,
   // assigned[0]
   output logic [0:0]            rsp_tuser
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_PS_RD   = 4'd2;
   localparam logic [3:0] S_EL      = 4'd3;
   localparam logic [3:0] S_REM     = 4'd4;
   localparam logic [3:0] S_PS_CMP  = 4'd5;
   localparam logic [3:0] S_EVICT   = 4'd6;
   localparam logic [3:0] S_EXPIRE  = 4'd7;
   localparam logic [3:0] S_EX_HEAD = 4'd8;
   localparam logic [3:0] S_DEQ     = 4'd9;
   localparam logic [3:0] S_ENQ     = 4'd10;
   localparam logic [3:0] S_FIND    = 4'd11;
   localparam logic [3:0] S_SHIFT   = 4'd12;
   localparam logic [3:0] S_INS     = 4'd13;
   localparam logic [3:0] S_DONE    = 4'd14;

   localparam logic [1:0] CTX_SCAN   = 2'd0;
   localparam logic [1:0] CTX_EVICT  = 2'd1;
   localparam logic [1:0] CTX_EXPIRE = 2'd2;

   cfg_type cfg;

   mjs_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   logic [3:0]            st_ff, st_in;
   logic [1:0]            ctx_ff, ctx_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [CIDX_W-1:0]     ci_ff, ci_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   entry_type             ne_ff, ne_in;
   entry_type             cur_ff, cur_in;
   entry_type             ins_ff, ins_in;
   logic [TIME_W-1:0]     el_ff, el_in;
   logic [CORE_CNT_W-1:0] cidx_ff, cidx_in;
   logic                  best_v_ff, best_v_in;
   logic [CORE_W-1:0]     best_core_ff, best_core_in;
   logic [TIME_W-1:0]     best_diff_ff, best_diff_in;
   logic [TIME_W-1:0]     best_arr_ff, best_arr_in;
   logic [QCNT_W-1:0]     qidx_ff, qidx_in;
   logic [QCNT_W-1:0]     pos_ff, pos_in;
   logic [QADDR_W-1:0]    head_ff, head_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic [MAX_CORES-1:0]  busy_ff, busy_in;
   logic                  r_asg_ff, r_asg_in;
   logic [CIDX_W-1:0]     r_core_ff, r_core_in;
   logic [JOB_W-1:0]      r_job_ff, r_job_in;
   logic                  r_ovf_ff, r_ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_asg_ff, out_asg_in;
   logic [CIDX_W-1:0]     out_core_ff, out_core_in;
   logic [JOB_W-1:0]      out_job_ff, out_job_in;
   logic                  out_ovf_ff, out_ovf_in;

   core_rec_type          core_mem [MAX_CORES];
   core_rec_type          core_rd_ff;
   logic                  c_we;
   logic [CORE_W-1:0]     c_waddr;
   core_rec_type          c_wdata;
   logic [CORE_W-1:0]     c_raddr;

   entry_type             q_mem [QUEUE_DEPTH];
   entry_type             q_rd_ff;
   logic                  q_we;
   logic [QADDR_W-1:0]    q_waddr;
   entry_type             q_wdata;
   logic [QADDR_W-1:0]    q_raddr;

   logic                  idle_found;
   logic [CORE_W-1:0]     idle_core;
   logic                  accept;
   logic                  load_out;
   logic                  ci_ok;
   logic [TIME_W-1:0]     diff;
   logic [QCNT_W-1:0]     qidx_dec;

   assign req_tready = (st_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = (st_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign ci_ok      = int'(ci_ff) < int'(cfg.n_cores);
   assign diff       = key_of(cfg.scheme, cur_ff) - key_of(cfg.scheme, ne_ff);
   assign qidx_dec   = qidx_ff - QCNT_W'(1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ovf_ff, out_job_ff, out_core_ff};
   assign rsp_tuser  = out_asg_ff;

   always_comb begin
      idle_found = 1'b0;
      idle_core  = '0;
      for (int c = MAX_CORES - 1; c >= 0; c--) begin
         if (!busy_ff[c] && (c < int'(cfg.n_cores))) begin
            idle_found = 1'b1;
            idle_core  = CORE_W'(c);
         end
      end
   end

   always_comb begin
      st_in        = st_ff;
      ctx_in       = ctx_ff;
      op_in        = op_ff;
      ci_in        = ci_ff;
      now_in       = now_ff;
      ne_in        = ne_ff;
      cur_in       = cur_ff;
      ins_in       = ins_ff;
      el_in        = el_ff;
      cidx_in      = cidx_ff;
      best_v_in    = best_v_ff;
      best_core_in = best_core_ff;
      best_diff_in = best_diff_ff;
      best_arr_in  = best_arr_ff;
      qidx_in      = qidx_ff;
      pos_in       = pos_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      busy_in      = busy_ff;
      r_asg_in     = r_asg_ff;
      r_core_in    = r_core_ff;
      r_job_in     = r_job_ff;
      r_ovf_in     = r_ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      out_asg_in   = out_asg_ff;
      out_core_in  = out_core_ff;
      out_job_in   = out_job_ff;
      out_ovf_in   = out_ovf_ff;
      c_we         = 1'b0;
      c_waddr      = '0;
      c_wdata      = '0;
      c_raddr      = '0;
      q_we         = 1'b0;
      q_waddr      = '0;
      q_wdata      = '0;
      q_raddr      = head_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_tuser;
               ci_in         = req_tdata[90:88];
               now_in        = req_tdata[47:16];
               ne_in.job     = req_tdata[15:0];
               ne_in.arrival = req_tdata[47:16];
               ne_in.total   = req_tdata[79:48];
               ne_in.left    = req_tdata[79:48];
               ne_in.prio    = req_tdata[87:80];
               r_asg_in      = 1'b0;
               r_core_in     = '0;
               r_job_in      = '0;
               r_ovf_in      = 1'b0;
               st_in         = S_DECODE;
            end
         end
         S_DECODE: begin
            if (op_ff == OP_NEW) begin
               if (idle_found) begin
                  c_we               = 1'b1;
                  c_waddr            = idle_core;
                  c_wdata            = '{ent: ne_ff, seg: now_ff};
                  busy_in[idle_core] = 1'b1;
                  r_asg_in           = 1'b1;
                  r_core_in          = CIDX_W'(idle_core);
                  r_job_in           = ne_ff.job;
                  st_in              = S_DONE;
               end else if (cfg.scheme inside {SCH_PSJF, SCH_PPRI}) begin
                  cidx_in   = '0;
                  best_v_in = 1'b0;
                  st_in     = S_PS_RD;
               end else begin
                  ins_in = ne_ff;
                  st_in  = S_ENQ;
               end
            end else if ((op_ff == OP_FINISH || op_ff == OP_EXPIRE) && ci_ok) begin
               if (op_ff == OP_EXPIRE && busy_ff[CORE_W'(ci_ff)]) begin
                  c_raddr = CORE_W'(ci_ff);
                  ctx_in  = CTX_EXPIRE;
                  st_in   = S_EL;
               end else begin
                  busy_in[CORE_W'(ci_ff)] = 1'b0;
                  st_in = (count_ff != '0) ? S_DEQ : S_DONE;
               end
            end else begin
               st_in = S_DONE;
            end
         end
         S_PS_RD: begin
            if (cidx_ff == cfg.n_cores) begin
               if (best_v_ff) begin
                  c_raddr = best_core_ff;
                  ctx_in  = CTX_EVICT;
                  st_in   = S_EL;
               end else begin
                  ins_in = ne_ff;
                  st_in  = S_ENQ;
               end
            end else begin
               c_raddr = CORE_W'(cidx_ff);
               ctx_in  = CTX_SCAN;
               st_in   = S_EL;
            end
         end
         S_EL: begin
            cur_in = core_rd_ff.ent;
            el_in  = now_ff - core_rd_ff.seg;
            st_in  = S_REM;
         end
         S_REM: begin
            cur_in.left = (el_ff >= cur_ff.left) ? '0 : cur_ff.left - el_ff;
            case (ctx_ff)
               CTX_SCAN:  st_in = S_PS_CMP;
               CTX_EVICT: st_in = S_EVICT;
               default:   st_in = S_EXPIRE;
            endcase
         end
         S_PS_CMP: begin
            if (sorts_before(cfg.scheme, ne_ff, cur_ff) &&
                (!best_v_ff || diff > best_diff_ff ||
                 (diff == best_diff_ff && cur_ff.arrival > best_arr_ff))) begin
               best_v_in    = 1'b1;
               best_core_in = CORE_W'(cidx_ff);
               best_diff_in = diff;
               best_arr_in  = cur_ff.arrival;
            end
            cidx_in = cidx_ff + CORE_CNT_W'(1);
            st_in   = S_PS_RD;
         end
         S_EVICT: begin
            c_we                  = 1'b1;
            c_waddr               = best_core_ff;
            c_wdata               = '{ent: ne_ff, seg: now_ff};
            busy_in[best_core_ff] = 1'b1;
            r_asg_in              = 1'b1;
            r_core_in             = CIDX_W'(best_core_ff);
            r_job_in              = ne_ff.job;
            ins_in                = cur_ff;
            st_in                 = S_ENQ;
         end
         S_EXPIRE: begin
            if (count_ff == '0) begin
               c_we      = 1'b1;
               c_waddr   = CORE_W'(ci_ff);
               c_wdata   = '{ent: cur_ff, seg: now_ff};
               r_asg_in  = 1'b1;
               r_core_in = ci_ff;
               r_job_in  = cur_ff.job;
               st_in     = S_DONE;
            end else begin
               st_in = S_EX_HEAD;
            end
         end
         S_EX_HEAD: begin
            c_we      = 1'b1;
            c_waddr   = CORE_W'(ci_ff);
            r_asg_in  = 1'b1;
            r_core_in = ci_ff;
            if (sorts_before(cfg.scheme, cur_ff, q_rd_ff)) begin
               c_wdata  = '{ent: cur_ff, seg: now_ff};
               r_job_in = cur_ff.job;
               st_in    = S_DONE;
            end else begin
               c_wdata  = '{ent: q_rd_ff, seg: now_ff};
               r_job_in = q_rd_ff.job;
               head_in  = head_ff + QADDR_W'(1);
               count_in = count_ff - QCNT_W'(1);
               ins_in   = cur_ff;
               st_in    = S_ENQ;
            end
         end
         S_DEQ: begin
            c_we                    = 1'b1;
            c_waddr                 = CORE_W'(ci_ff);
            c_wdata                 = '{ent: q_rd_ff, seg: now_ff};
            busy_in[CORE_W'(ci_ff)] = 1'b1;
            r_asg_in                = 1'b1;
            r_core_in               = ci_ff;
            r_job_in                = q_rd_ff.job;
            head_in                 = head_ff + QADDR_W'(1);
            count_in                = count_ff - QCNT_W'(1);
            st_in                   = S_DONE;
         end
         S_ENQ: begin
            if (count_ff >= QCNT_W'(QUEUE_DEPTH)) begin
               r_ovf_in = 1'b1;
               st_in    = S_DONE;
            end else if (count_ff == '0) begin
               pos_in = '0;
               st_in  = S_INS;
            end else begin
               qidx_in = '0;
               st_in   = S_FIND;
            end
         end
         S_FIND: begin
            if (sorts_before(cfg.scheme, ins_ff, q_rd_ff)) begin
               pos_in  = qidx_ff;
               q_raddr = head_ff + QADDR_W'(count_ff - QCNT_W'(1));
               qidx_in = count_ff;
               st_in   = S_SHIFT;
            end else if (qidx_ff + QCNT_W'(1) == count_ff) begin
               pos_in = count_ff;
               st_in  = S_INS;
            end else begin
               q_raddr = head_ff + QADDR_W'(qidx_ff + QCNT_W'(1));
               qidx_in = qidx_ff + QCNT_W'(1);
            end
         end
         S_SHIFT: begin
            q_we    = 1'b1;
            q_waddr = head_ff + QADDR_W'(qidx_ff);
            q_wdata = q_rd_ff;
            if (qidx_dec == pos_ff) begin
               st_in = S_INS;
            end else begin
               q_raddr = head_ff + QADDR_W'(qidx_ff - QCNT_W'(2));
               qidx_in = qidx_dec;
            end
         end
         S_INS: begin
            q_we     = 1'b1;
            q_waddr  = head_ff + QADDR_W'(pos_ff);
            q_wdata  = ins_ff;
            count_in = count_ff + QCNT_W'(1);
            st_in    = S_DONE;
         end
         S_DONE: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               out_asg_in   = r_asg_ff;
               out_core_in  = r_core_ff;
               out_job_in   = r_job_ff;
               out_ovf_in   = r_ovf_ff;
               st_in        = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         core_mem[c_waddr] <= c_wdata;
      end
      core_rd_ff <= core_mem[c_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_waddr] <= q_wdata;
      end
      q_rd_ff <= q_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         busy_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         busy_ff      <= busy_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff       <= ctx_in;
      op_ff        <= op_in;
      ci_ff        <= ci_in;
      now_ff       <= now_in;
      ne_ff        <= ne_in;
      cur_ff       <= cur_in;
      ins_ff       <= ins_in;
      el_ff        <= el_in;
      cidx_ff      <= cidx_in;
      best_v_ff    <= best_v_in;
      best_core_ff <= best_core_in;
      best_diff_ff <= best_diff_in;
      best_arr_ff  <= best_arr_in;
      qidx_ff      <= qidx_in;
      pos_ff       <= pos_in;
      r_asg_ff     <= r_asg_in;
      r_core_ff    <= r_core_in;
      r_job_ff     <= r_job_in;
      r_ovf_ff     <= r_ovf_in;
      out_asg_ff   <= out_asg_in;
      out_core_ff  <= out_core_in;
      out_job_ff   <= out_job_in;
      out_ovf_ff   <= out_ovf_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("wait queue count exceeds its depth");

   a_assigned_busy: assert property (@(posedge clock) disable iff (reset)
      (load_out && r_asg_ff) |=> busy_ff[CORE_W'(out_core_ff)])
      else $error("assigned beat names a core that is not busy");

   a_ovf_new_only: assert property (@(posedge clock) disable iff (reset)
      (load_out && r_ovf_ff) |-> (op_ff == OP_NEW))
      else $error("overflow reported for an event other than a new job");

endmodule

[hw/rtl/mjs_cfg.sv]
// Configuration registers of the job scheduler behind an APB-style port.
// Depends on mjs_pkg; hands the scheme and the clamped core count to the top level.
module mjs_cfg import mjs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [SCHEME_W-1:0] scheme_ff, scheme_in;
   logic [ACT_W-1:0]    active_ff, active_in;
   logic                wr;
   logic                idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx = csr_paddr[2];

   always_comb begin
      scheme_in = scheme_ff;
      active_in = active_ff;
      if (wr) begin
         case (idx)
            REG_SCHEME: scheme_in = csr_pwdata[SCHEME_W-1:0];
            REG_ACTIVE: active_in = csr_pwdata[ACT_W-1:0];
            default:    scheme_in = scheme_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SCHEME: csr_prdata = CSR_DATA_W'(scheme_ff);
         REG_ACTIVE: csr_prdata = CSR_DATA_W'(active_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.scheme = scheme_ff;
      if (active_ff == '0) begin
         cfg.n_cores = CORE_CNT_W'(1);
      end else if (int'(active_ff) > MAX_CORES) begin
         cfg.n_cores = CORE_CNT_W'(MAX_CORES);
      end else begin
         cfg.n_cores = CORE_CNT_W'(active_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= SCH_FCFS;
         active_ff <= ACT_W'(1);
      end else begin
         scheme_ff <= scheme_in;
         active_ff <= active_in;
      end
   end

endmodule
